>>> rtl/core/astar_shortest_path_top_defines.svh
// ----------------------------------------------------------------------------
// A* path engine assertion macros
// Concurrent check wrappers used by the RTL top file of the path engine.
// ----------------------------------------------------------------------------
`ifndef ASTAR_SHORTEST_PATH_TOP_DEFINES_SVH
`define ASTAR_SHORTEST_PATH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and masked during reset.
`define ASP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk and masked during reset.
`define ASP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASP_ASSERT_IMP(lbl, ante, cons, msg)
`define ASP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/asp_pkg.sv
// ----------------------------------------------------------------------------
// A* path engine package
// Widths, codes, payload structs and the state type of the path engine.
// ----------------------------------------------------------------------------
`default_nettype none

package asp_pkg;

  // Graph sizes.
  localparam int NV      = 32;
  localparam int VTX_W   = 5;
  localparam int DEG     = 8;
  localparam int DEG_W   = 3;
  localparam int CNT_W   = 4;
  localparam int CRD_W   = 20;
  localparam int COST_W  = 32;
  localparam int EST_W   = 22;
  localparam int PAR_W   = 6;
  localparam int CFG_W   = 6;
  localparam int LEN_W   = 6;
  localparam int SQ_W    = 42;
  localparam int ROOT_W  = 21;
  localparam int NBR_AW  = VTX_W + DEG_W;

  localparam logic [PAR_W-1:0] PARENT_NONE = '1;
  localparam logic [CFG_W-1:0] CFG_RESET   = CFG_W'(NV);

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_EDGE  = 2'd1,
    FUNC_FIND  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_PATH = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    func_t                    func;
    logic [VTX_W-1:0]         vertex_index;
    logic [VTX_W-1:0]         other_index;
    logic signed [CRD_W-1:0]  coord_x;
    logic signed [CRD_W-1:0]  coord_y;
    logic signed [CRD_W-1:0]  coord_z;
    logic [VTX_W-1:0]         start_vertex;
    logic [VTX_W-1:0]         goal_vertex;
  } cmd_t;

  typedef struct packed {
    logic [VTX_W-1:0]  path_vertex;
    status_t           status;
    logic [COST_W-1:0] path_cost;
    logic              last;
  } res_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic [COST_W-1:0] g;
    logic [EST_W-1:0]  h;
    logic [PAR_W-1:0]  parent;
  } node_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RESP,
    S_E_RDB,
    S_E_CHK,
    S_E_WR2,
    S_S_INIT,
    S_ITER,
    S_SCAN,
    S_PICK,
    S_NCNT,
    S_NB,
    S_NB_D,
    S_RELAX_A,
    S_RELAX_B,
    S_RELAX_W,
    S_PT,
    S_PT_D,
    S_PCHK,
    S_EM_RD,
    S_EM_OUT,
    S_D_A,
    S_D_B,
    S_D_DIFF,
    S_D_MUL,
    S_D_SQRT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/astar_shortest_path_top.sv
// ----------------------------------------------------------------------------
// A* path engine
// Stores a small 3-D graph in on-chip memories and runs A* searches with a
// Euclidean heuristic, streaming the found path one vertex per transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  cmd       in         cmd_valid / cmd_stall     cmd_t (func, indices, coords)
//  res       out        res_valid / res_stall     res_t (vertex, status, cost)
//  cfg       in         cfg_we                    cfg_wdata (vertices in use)
//
//  A distance needs two coordinate reads, three passes through one shared
//  20x20 multiplier and 21 steps of a bit-serial square root.
//  A search with n vertices runs up to n+1 expansions, each a scan of the node
//  memory plus up to 8 neighbors.
//  Reset is synchronous; it clears control, the valid bits of the coordinate
//  and degree memories, and sets vertices in use to 32.
//  Result stalls hold the engine at its next result; one command is taken at
//  a time, and a new one while the last result still waits.
//
`default_nettype none

`include "astar_shortest_path_top_defines.svh"

module astar_shortest_path_top
  import asp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_stall,
  input  wire cmd_t             cmd,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output res_t                  res,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  // State and command registers.
  state_t             state, state_next, ret_state;
  cmd_t               cmd_q;
  logic [CFG_W-1:0]   vertices_in_use;
  logic [CFG_W-1:0]   n_cur, n_eff;
  logic               accept;

  // Memories.
  pos_t               pos_mem [NV];
  logic [NV-1:0]      pos_valid;
  logic               pos_we;
  logic [VTX_W-1:0]   pos_raddr;
  pos_t               pos_q, pos_rd;
  logic               pos_vq;

  logic [CNT_W-1:0]   cnt_mem [NV];
  logic [NV-1:0]      cnt_valid;
  logic               cnt_we, cnt_clear;
  logic [VTX_W-1:0]   cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]   cnt_wdata, cnt_q, cnt_rd;
  logic               cnt_vq;

  logic [VTX_W-1:0]   nbr_mem [NV*DEG];
  logic               nbr_we;
  logic [NBR_AW-1:0]  nbr_waddr, nbr_raddr;
  logic [VTX_W-1:0]   nbr_wdata, nbr_q;

  node_t              node_mem [NV];
  logic               node_we;
  logic [VTX_W-1:0]   node_waddr, node_raddr;
  node_t              node_wdata, node_q;

  logic [VTX_W-1:0]   stk_mem [NV];
  logic               stk_we;
  logic [VTX_W-1:0]   stk_waddr, stk_raddr, stk_wdata, stk_q;

  // Search bookkeeping.
  logic [NV-1:0]      open_bits, closed_bits;
  logic [LEN_W-1:0]   iter, si, idx, len;
  logic               scan_v, best_v;
  logic [VTX_W-1:0]   scan_idx, best, nb, pv;
  logic [COST_W:0]    best_f, scan_f;
  logic [COST_W-1:0]  best_g, tg;
  logic [COST_W:0]    tg_sum;
  logic [CNT_W-1:0]   ca, cb_eff, nb_cnt;
  logic [CNT_W:0]     ca_plus2;
  logic               edge_full, seen;
  status_t            resp_code, resp_code_next;

  // Distance unit.
  logic [VTX_W-1:0]   da, db;
  pos_t               pa;
  logic [CRD_W-1:0]   dx, dy, dz, msel;
  logic [1:0]         mcnt;
  logic [2*CRD_W-1:0] prod;
  logic [SQ_W-1:0]    acc, sq_x, sq_r, sq_bit, sq_trial;
  logic               call_dist;
  logic [VTX_W-1:0]   call_a, call_b;
  state_t             call_ret;

  // Result register.
  logic               out_free, out_load;
  res_t               out_next;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != S_IDLE);
  assign out_free  = !res_valid || !res_stall;
  assign n_cur     = (vertices_in_use > CFG_W'(NV)) ? CFG_W'(NV) : vertices_in_use;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertices_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      vertices_in_use <= cfg_wdata;
    end
  end

  // Coordinate memory; entries never written read as zero.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[cmd.vertex_index] <= '{x: cmd.coord_x, y: cmd.coord_y, z: cmd.coord_z};
    end
    pos_q  <= pos_mem[pos_raddr];
    pos_vq <= pos_valid[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_valid <= '0;
    end else if (pos_we) begin
      pos_valid[cmd.vertex_index] <= 1'b1;
    end
  end

  assign pos_rd = pos_vq ? pos_q : '0;

  // Degree memory; a clear drops every valid bit at once.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q  <= cnt_mem[cnt_raddr];
    cnt_vq <= cnt_valid[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || cnt_clear) begin
      cnt_valid <= '0;
    end else if (cnt_we) begin
      cnt_valid[cnt_waddr] <= 1'b1;
    end
  end

  assign cnt_rd = cnt_vq ? cnt_q : '0;

  // Adjacency, node and path stack memories.
  always_ff @(posedge clk) begin
    if (nbr_we) begin
      nbr_mem[nbr_waddr] <= nbr_wdata;
    end
    nbr_q <= nbr_mem[nbr_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  // Derived values used by the controller.
  assign scan_f   = {1'b0, node_q.g} + (COST_W+1)'(node_q.h);
  assign tg_sum   = {1'b0, best_g} + (COST_W+1)'(sq_r[ROOT_W-1:0]);
  assign ca_plus2 = {1'b0, ca} + (CNT_W+1)'(2);
  assign edge_full = (cmd_q.vertex_index == cmd_q.other_index)
                   ? (ca_plus2 > (CNT_W+1)'(DEG))
                   : ((ca >= CNT_W'(DEG)) || (cnt_rd >= CNT_W'(DEG)));
  assign seen     = open_bits[nb] || closed_bits[nb];
  assign sq_trial = sq_r + sq_bit;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory controls and result loading.
  always_comb begin
    state_next     = state;
    pos_we         = 1'b0;
    pos_raddr      = da;
    cnt_we         = 1'b0;
    cnt_clear      = 1'b0;
    cnt_waddr      = cmd_q.vertex_index;
    cnt_wdata      = '0;
    cnt_raddr      = cmd_q.other_index;
    nbr_we         = 1'b0;
    nbr_waddr      = '0;
    nbr_wdata      = '0;
    nbr_raddr      = {best, idx[DEG_W-1:0]};
    node_we        = 1'b0;
    node_waddr     = nb;
    node_wdata     = '{g: tg, h: sq_r[EST_W-1:0], parent: {1'b0, best}};
    node_raddr     = si[VTX_W-1:0];
    stk_we         = 1'b0;
    stk_waddr      = len[VTX_W-1:0];
    stk_wdata      = pv;
    stk_raddr      = VTX_W'(len - idx - LEN_W'(1));
    out_load       = 1'b0;
    out_next       = '{path_vertex: '0, status: resp_code, path_cost: '0, last: 1'b1};
    call_dist      = 1'b0;
    call_a         = best;
    call_b         = nb;
    call_ret       = S_RELAX_A;
    resp_code_next = resp_code;
    unique case (state)
      S_IDLE: begin
        cnt_raddr = cmd.vertex_index;
        if (accept) begin
          unique case (cmd.func)
            FUNC_WRITE: begin
              pos_we         = 1'b1;
              resp_code_next = ST_OK;
              state_next     = S_RESP;
            end
            FUNC_EDGE: begin
              state_next = S_E_RDB;
            end
            FUNC_FIND: begin
              if ((CFG_W'(cmd.start_vertex) >= n_cur) ||
                  (CFG_W'(cmd.goal_vertex) >= n_cur)) begin
                resp_code_next = ST_RANGE;
                state_next     = S_RESP;
              end else begin
                call_dist = 1'b1;
                call_a    = cmd.start_vertex;
                call_b    = cmd.goal_vertex;
                call_ret  = S_S_INIT;
              end
            end
            FUNC_CLEAR: begin
              cnt_clear      = 1'b1;
              resp_code_next = ST_OK;
              state_next     = S_RESP;
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      // Edge add: both degrees read, then two appends unless a list is full.
      S_E_RDB: begin
        state_next = S_E_CHK;
      end
      S_E_CHK: begin
        if (edge_full) begin
          resp_code_next = ST_FULL;
          state_next     = S_RESP;
        end else begin
          nbr_we     = 1'b1;
          nbr_waddr  = {cmd_q.vertex_index, ca[DEG_W-1:0]};
          nbr_wdata  = cmd_q.other_index;
          cnt_we     = 1'b1;
          cnt_wdata  = ca + CNT_W'(1);
          state_next = S_E_WR2;
        end
      end
      S_E_WR2: begin
        nbr_we         = 1'b1;
        nbr_waddr      = {cmd_q.other_index, cb_eff[DEG_W-1:0]};
        nbr_wdata      = cmd_q.vertex_index;
        cnt_we         = 1'b1;
        cnt_waddr      = cmd_q.other_index;
        cnt_wdata      = cb_eff + CNT_W'(1);
        resp_code_next = ST_OK;
        state_next     = S_RESP;
      end
      // Search setup: the start node enters the open set.
      S_S_INIT: begin
        node_we    = 1'b1;
        node_waddr = cmd_q.start_vertex;
        node_wdata = '{g: '0, h: sq_r[EST_W-1:0], parent: PARENT_NONE};
        state_next = S_ITER;
      end
      S_ITER: begin
        if (iter > n_eff) begin
          resp_code_next = ST_NO_PATH;
          state_next     = S_RESP;
        end else begin
          state_next = S_SCAN;
        end
      end
      // Open-set scan, one node read a cycle.
      S_SCAN: begin
        if ((si >= n_eff) && !scan_v) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cnt_raddr = best;
        if (!best_v) begin
          resp_code_next = ST_NO_PATH;
          state_next     = S_RESP;
        end else if (best == cmd_q.goal_vertex) begin
          state_next = S_PT;
        end else begin
          state_next = S_NCNT;
        end
      end
      S_NCNT: begin
        state_next = S_NB;
      end
      S_NB: begin
        if (idx >= LEN_W'(nb_cnt)) begin
          state_next = S_ITER;
        end else begin
          state_next = S_NB_D;
        end
      end
      S_NB_D: begin
        if (CFG_W'(nbr_q) >= n_eff) begin
          state_next = S_NB;
        end else begin
          call_dist = 1'b1;
          call_a    = best;
          call_b    = nbr_q;
          call_ret  = S_RELAX_A;
        end
      end
      S_RELAX_A: begin
        node_raddr = nb;
        state_next = S_RELAX_B;
      end
      S_RELAX_B: begin
        if (!seen || (tg < node_q.g)) begin
          call_dist = 1'b1;
          call_a    = nb;
          call_b    = cmd_q.goal_vertex;
          call_ret  = S_RELAX_W;
        end else begin
          state_next = S_NB;
        end
      end
      S_RELAX_W: begin
        node_we    = 1'b1;
        state_next = S_NB;
      end
      // Parent chain walk from the goal into the path stack.
      S_PT: begin
        node_raddr = pv;
        if (len >= n_eff) begin
          state_next = S_PCHK;
        end else begin
          stk_we     = 1'b1;
          state_next = S_PT_D;
        end
      end
      S_PT_D: begin
        if (node_q.parent == PARENT_NONE) begin
          state_next = S_PCHK;
        end else begin
          state_next = S_PT;
        end
      end
      S_PCHK: begin
        if (pv != cmd_q.start_vertex) begin
          resp_code_next = ST_NO_PATH;
          state_next     = S_RESP;
        end else begin
          state_next = S_EM_RD;
        end
      end
      // Path output, start first.
      S_EM_RD: begin
        state_next = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_next = '{path_vertex: stk_q, status: ST_OK, path_cost: best_g,
                       last: (idx + LEN_W'(1) == len)};
          state_next = (idx + LEN_W'(1) == len) ? S_IDLE : S_EM_RD;
        end
      end
      // Distance unit sequence.
      S_D_A: begin
        state_next = S_D_B;
      end
      S_D_B: begin
        pos_raddr  = db;
        state_next = S_D_DIFF;
      end
      S_D_DIFF: begin
        state_next = S_D_MUL;
      end
      S_D_MUL: begin
        if (mcnt == 2'd3) begin
          state_next = S_D_SQRT;
        end
      end
      S_D_SQRT: begin
        if (sq_bit[0]) begin
          state_next = ret_state;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (call_dist) begin
      state_next = S_D_A;
    end
  end

  // Absolute coordinate difference, as an unsigned magnitude.
  function automatic logic [CRD_W-1:0] abs_diff(input logic signed [CRD_W-1:0] a,
                                                input logic signed [CRD_W-1:0] b);
    logic signed [CRD_W:0] d;
    d = $signed({a[CRD_W-1], a}) - $signed({b[CRD_W-1], b});
    abs_diff = d[CRD_W] ? CRD_W'(-d) : d[CRD_W-1:0];
  endfunction

  always_comb begin
    unique case (mcnt)
      2'd0:    msel = dx;
      2'd1:    msel = dy;
      default: msel = dz;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (call_dist) begin
      da        <= call_a;
      db        <= call_b;
      ret_state <= call_ret;
    end
    resp_code <= resp_code_next;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_q <= cmd;
          n_eff <= n_cur;
          iter  <= '0;
        end
      end
      S_E_RDB: begin
        ca <= cnt_rd;
      end
      S_E_CHK: begin
        cb_eff <= (cmd_q.vertex_index == cmd_q.other_index) ? ca + CNT_W'(1) : cnt_rd;
      end
      S_ITER: begin
        si     <= '0;
        scan_v <= 1'b0;
        best_v <= 1'b0;
      end
      S_SCAN: begin
        if (scan_v && open_bits[scan_idx] && (!best_v || (scan_f < best_f))) begin
          best_v <= 1'b1;
          best   <= scan_idx;
          best_f <= scan_f;
          best_g <= node_q.g;
        end
        if (si < n_eff) begin
          scan_v   <= 1'b1;
          scan_idx <= si[VTX_W-1:0];
          si       <= si + LEN_W'(1);
        end else begin
          scan_v <= 1'b0;
        end
      end
      S_PICK: begin
        idx <= '0;
        len <= '0;
        pv  <= cmd_q.goal_vertex;
      end
      S_NCNT: begin
        nb_cnt <= (cnt_rd > CNT_W'(DEG)) ? CNT_W'(DEG) : cnt_rd;
      end
      S_NB: begin
        if (idx >= LEN_W'(nb_cnt)) begin
          iter <= iter + LEN_W'(1);
        end
      end
      S_NB_D: begin
        nb <= nbr_q;
        if (CFG_W'(nbr_q) >= n_eff) begin
          idx <= idx + LEN_W'(1);
        end
      end
      S_RELAX_A: begin
        tg <= tg_sum[COST_W] ? '1 : tg_sum[COST_W-1:0];
      end
      S_RELAX_B: begin
        if (seen && !(tg < node_q.g)) begin
          idx <= idx + LEN_W'(1);
        end
      end
      S_RELAX_W: begin
        idx <= idx + LEN_W'(1);
      end
      S_PT: begin
        if (len < n_eff) begin
          len <= len + LEN_W'(1);
        end
      end
      S_PT_D: begin
        if (node_q.parent != PARENT_NONE) begin
          pv <= node_q.parent[VTX_W-1:0];
        end
      end
      S_PCHK: begin
        idx <= '0;
      end
      S_EM_OUT: begin
        if (out_free) begin
          idx <= idx + LEN_W'(1);
        end
      end
      S_D_B: begin
        pa <= pos_rd;
      end
      S_D_DIFF: begin
        dx   <= abs_diff(pa.x, pos_rd.x);
        dy   <= abs_diff(pa.y, pos_rd.y);
        dz   <= abs_diff(pa.z, pos_rd.z);
        mcnt <= '0;
      end
      S_D_MUL: begin
        prod <= msel * msel;
        mcnt <= mcnt + 2'd1;
        unique case (mcnt)
          2'd0: ;
          2'd1: acc <= SQ_W'(prod);
          2'd2: acc <= acc + SQ_W'(prod);
          default: begin
            sq_x   <= acc + SQ_W'(prod);
            sq_r   <= '0;
            sq_bit <= SQ_W'(1) << (SQ_W - 2);
          end
        endcase
      end
      S_D_SQRT: begin
        if (sq_x >= sq_trial) begin
          sq_x <= sq_x - sq_trial;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      default: ;
    endcase
  end

  // Open and closed marks, cleared at the start of every search.
  always_ff @(posedge clk) begin
    if (rst) begin
      open_bits   <= '0;
      closed_bits <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (cmd.func == FUNC_FIND)) begin
            open_bits   <= '0;
            closed_bits <= '0;
          end
        end
        S_S_INIT: begin
          open_bits[cmd_q.start_vertex] <= 1'b1;
        end
        S_PICK: begin
          if (best_v && (best != cmd_q.goal_vertex)) begin
            open_bits[best]   <= 1'b0;
            closed_bits[best] <= 1'b1;
          end
        end
        S_RELAX_W: begin
          if (!seen) begin
            open_bits[nb] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= out_next;
    end
  end

  // Checks.
  `ASP_ASSERT_IMP(a_no_overwrite, out_load, (!res_valid || !res_stall), "result overwritten")
  `ASP_ASSERT_IMP(a_marks_disjoint, 1'b1, ((open_bits & closed_bits) == '0), "open and closed overlap")
  `ASP_ASSERT_IMP(a_path_len, (state == S_EM_RD), ((len != '0) && (len <= n_eff)), "bad path length")
  `ASP_ASSERT_NXT(a_find_busy, (accept && (cmd.func == FUNC_FIND)), (state != S_IDLE), "search not started")

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// A* path engine testbench
// Drives coordinate writes, edge adds, edge clears and searches into the path
// engine, predicts every result transaction with a behavioral A* model, and
// compares the results field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import asp_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DIRECTED_ROWS  = 20;
  localparam int RANDOM_ITEMS   = 80;
  localparam int CALM_ITEMS     = 15;
  localparam int SETTLE_CYCLES  = 2000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_stall;
  cmd_t             cmd = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  res_t             res;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  astar_shortest_path_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Shadow copy of the graph and the register.
  logic signed [CRD_W-1:0] mx [NV];
  logic signed [CRD_W-1:0] my [NV];
  logic signed [CRD_W-1:0] mz [NV];
  logic [VTX_W-1:0]        adj [NV][DEG];
  int                      deg [NV];
  int                      active_vertices;

  res_t path_results [$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   calm = 1'b0;
  bit   stim_done = 1'b0;

  // Appends one expected result transaction at the tail of the queue.
  task automatic queue_result(res_t r);
    path_results.insert(path_results.size(), r);
  endtask

  // Floor of the Euclidean distance between two stored vertices.
  function automatic logic [31:0] euclid(int a, int b);
    logic [63:0] dx, dy, dz, s, r, bitv;
    dx = (mx[a] >= mx[b]) ? 64'(mx[a] - mx[b]) : 64'(mx[b] - mx[a]);
    dy = (my[a] >= my[b]) ? 64'(my[a] - my[b]) : 64'(my[b] - my[a]);
    dz = (mz[a] >= mz[b]) ? 64'(mz[a] - mz[b]) : 64'(mz[b] - mz[a]);
    s = dx * dx + dy * dy + dz * dz;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= r + bitv) begin
        s = s - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r[31:0];
  endfunction

  function automatic res_t mk(int v, status_t st, logic [31:0] c, bit l);
    res_t r;
    r.path_vertex = VTX_W'(v);
    r.status = st;
    r.path_cost = c;
    r.last = l;
    return r;
  endfunction

  // A* with ties to the lowest index; appends the results to the queue.
  task automatic predict_search(int s, int goal);
    logic [31:0] g [NV];
    logic [31:0] h [NV];
    int          par [NV];
    bit          op [NV], cl [NV];
    int          chain [NV];
    int          n, best, len, v, nb;
    logic [63:0] f, bestf, t;
    logic [31:0] tg;
    n = active_vertices > NV ? NV : active_vertices;
    if (s >= n || goal >= n) begin
      queue_result(mk(0, ST_RANGE, 0, 1'b1));
      return;
    end
    for (int i = 0; i < NV; i++) begin
      g[i] = 0; h[i] = 0; par[i] = -1; op[i] = 0; cl[i] = 0;
    end
    h[s] = euclid(s, goal);
    op[s] = 1;
    for (int it = 0; it <= n; it++) begin
      best = -1;
      bestf = 0;
      for (int i = 0; i < n; i++) begin
        if (op[i]) begin
          f = 64'(g[i]) + 64'(h[i]);
          if (best < 0 || f < bestf) begin
            best = i;
            bestf = f;
          end
        end
      end
      if (best < 0) break;
      if (best == goal) begin
        len = 0;
        v = goal;
        forever begin
          if (len >= n) break;
          chain[len] = v;
          len++;
          if (par[v] < 0) break;
          v = par[v];
        end
        if (v != s || par[v] >= 0) break;
        for (int k = 0; k < len; k++)
          queue_result(mk(chain[len-1-k], ST_OK, g[goal], k + 1 == len));
        return;
      end
      op[best] = 0;
      cl[best] = 1;
      for (int k = 0; k < deg[best]; k++) begin
        nb = adj[best][k];
        if (nb >= n) continue;
        t = 64'(g[best]) + 64'(euclid(best, nb));
        tg = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        if (cl[nb] || op[nb]) begin
          if (tg < g[nb]) begin
            par[nb] = best; g[nb] = tg; h[nb] = euclid(nb, goal);
          end
        end else begin
          par[nb] = best; g[nb] = tg; h[nb] = euclid(nb, goal); op[nb] = 1;
        end
      end
    end
    queue_result(mk(0, ST_NO_PATH, 0, 1'b1));
  endtask

  // Updates the shadow graph for one command and queues its results.
  task automatic predict_cmd(cmd_t c);
    int a, b;
    a = c.vertex_index;
    b = c.other_index;
    case (c.func)
      FUNC_WRITE: begin
        mx[a] = c.coord_x; my[a] = c.coord_y; mz[a] = c.coord_z;
        queue_result(mk(0, ST_OK, 0, 1'b1));
      end
      FUNC_EDGE: begin
        if ((a == b && deg[a] + 2 > DEG) || deg[a] >= DEG || deg[b] >= DEG) begin
          queue_result(mk(0, ST_FULL, 0, 1'b1));
        end else begin
          adj[a][deg[a]] = VTX_W'(b); deg[a]++;
          adj[b][deg[b]] = VTX_W'(a); deg[b]++;
          queue_result(mk(0, ST_OK, 0, 1'b1));
        end
      end
      FUNC_FIND: predict_search(c.start_vertex, c.goal_vertex);
      default: begin
        for (int i = 0; i < NV; i++) deg[i] = 0;
        queue_result(mk(0, ST_OK, 0, 1'b1));
      end
    endcase
  endtask

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result checker with random stall bursts.
  int stall_left = 0;
  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && res_valid && !res_stall) begin
      if (path_results.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual %h", $time, res);
      end else begin
        exp_r = path_results.pop_front();
        if (res.path_vertex !== exp_r.path_vertex) begin
          errors++;
          $display("%0t: path_vertex expected %0d actual %0d", $time,
                   exp_r.path_vertex, res.path_vertex);
        end
        if (res.status !== exp_r.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, res.status);
        end
        if (res.path_cost !== exp_r.path_cost) begin
          errors++;
          $display("%0t: path_cost expected %0d actual %0d", $time,
                   exp_r.path_cost, res.path_cost);
        end
        if (res.last !== exp_r.last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b", $time, exp_r.last, res.last);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 11);
    end
    res_stall <= calm ? 1'b0 : (stall_left > 0);
  end

  // Sends one command transaction, with an optional random gap first.
  // Valid stays high after acceptance until the next command or a gap.
  task automatic send(cmd_t c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    predict_cmd(c);
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (path_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertices(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    active_vertices = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic cmd_t row(func_t f, int a, int b, int x, int y, int z, int s, int g);
    cmd_t c;
    c.func = f; c.vertex_index = VTX_W'(a); c.other_index = VTX_W'(b);
    c.coord_x = CRD_W'(x); c.coord_y = CRD_W'(y); c.coord_z = CRD_W'(z);
    c.start_vertex = VTX_W'(s); c.goal_vertex = VTX_W'(g);
    return c;
  endfunction

  // Random command: mostly small graphs built from well-formed edges.
  function automatic cmd_t rand_cmd(int span);
    cmd_t        c;
    int          p;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    p = $urandom_range(0, 99);
    if (p < 30) c.func = FUNC_WRITE;
    else if (p < 65) c.func = FUNC_EDGE;
    else if (p < 95) c.func = FUNC_FIND;
    else c.func = FUNC_CLEAR;
    if ($urandom_range(0, 3) != 0) begin
      c.vertex_index = VTX_W'($urandom_range(0, span - 1));
      c.other_index  = VTX_W'($urandom_range(0, span - 1));
      c.start_vertex = VTX_W'($urandom_range(0, span - 1));
      c.goal_vertex  = VTX_W'($urandom_range(0, span - 1));
      if ($urandom_range(0, 2) != 0) begin
        c.coord_x = CRD_W'($signed($urandom_range(0, 2000)) - 1000);
        c.coord_y = CRD_W'($signed($urandom_range(0, 2000)) - 1000);
        c.coord_z = CRD_W'($signed($urandom_range(0, 2000)) - 1000);
      end
    end
    return c;
  endfunction

  cmd_t directed [DIRECTED_ROWS];
  res_t directed_exp [DIRECTED_ROWS];
  bit   directed_typed [DIRECTED_ROWS];

  initial begin
    res_t got;
    for (int i = 0; i < NV; i++) begin
      mx[i] = 0; my[i] = 0; mz[i] = 0; deg[i] = 0;
    end
    active_vertices = NV;

    // Directed table: extremes, every function, self loops, full lists,
    // unreachable goals and a trivial path.
    directed[0]  = row(FUNC_FIND, 0, 0, 0, 0, 0, 0, 0);
    directed[1]  = row(FUNC_FIND, 0, 0, 0, 0, 0, 0, 5);
    directed[2]  = row(FUNC_WRITE, 0, 0, -524288, -524288, -524288, 0, 0);
    directed[3]  = row(FUNC_WRITE, 31, 0, 524287, 524287, 524287, 0, 0);
    directed[4]  = row(FUNC_EDGE, 0, 31, 0, 0, 0, 0, 0);
    directed[5]  = row(FUNC_FIND, 0, 0, 0, 0, 0, 0, 31);
    directed[6]  = row(FUNC_WRITE, 1, 0, 3, 4, 0, 0, 0);
    directed[7]  = row(FUNC_WRITE, 2, 0, 6, 8, 0, 0, 0);
    directed[8]  = row(FUNC_EDGE, 1, 2, 0, 0, 0, 0, 0);
    directed[9]  = row(FUNC_EDGE, 2, 3, 0, 0, 0, 0, 0);
    directed[10] = row(FUNC_EDGE, 1, 3, 0, 0, 0, 0, 0);
    directed[11] = row(FUNC_FIND, 0, 0, 0, 0, 0, 1, 3);
    directed[12] = row(FUNC_EDGE, 5, 5, 0, 0, 0, 0, 0);
    directed[13] = row(FUNC_EDGE, 5, 5, 0, 0, 0, 0, 0);
    directed[14] = row(FUNC_EDGE, 5, 5, 0, 0, 0, 0, 0);
    directed[15] = row(FUNC_EDGE, 5, 5, 0, 0, 0, 0, 0);
    directed[16] = row(FUNC_EDGE, 5, 5, 0, 0, 0, 0, 0);
    directed[17] = row(FUNC_FIND, 0, 0, 0, 0, 0, 1, 6);
    directed[18] = row(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    directed[19] = row(FUNC_FIND, 0, 0, 0, 0, 0, 1, 3);
    for (int i = 0; i < DIRECTED_ROWS; i++) directed_typed[i] = 0;
    directed_typed[0] = 1; directed_exp[0] = mk(0, ST_OK, 0, 1'b1);
    directed_typed[2] = 1; directed_exp[2] = mk(0, ST_OK, 0, 1'b1);
    directed_typed[16] = 1; directed_exp[16] = mk(0, ST_FULL, 0, 1'b1);
    directed_typed[19] = 1; directed_exp[19] = mk(0, ST_NO_PATH, 0, 1'b1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part; typed rows are checked against the predictor too.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send(directed[i]);
      if (directed_typed[i]) begin
        got = path_results[path_results.size() - 1];
        if (got !== directed_exp[i]) begin
          errors++;
          $display("%0t: row %0d expected %h actual prediction %h", $time, i,
                   directed_exp[i], got);
        end
      end
    end
    // Hold off until every result is back, then go on.
    drain();

    // Random phases under several register settings, extremes included.
    set_vertices(1);
    for (int i = 0; i < 6; i++) send(rand_cmd(4));
    send(row(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    set_vertices(6);
    for (int i = 0; i < 20; i++) send(rand_cmd(8));
    set_vertices(63);
    for (int i = 0; i < 20; i++) send(rand_cmd(12));
    send(row(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    set_vertices(NV);
    for (int i = 0; i < RANDOM_ITEMS - 48 - CALM_ITEMS; i++) send(rand_cmd(NV));
    calm = 1'b1;
    for (int i = 0; i < CALM_ITEMS; i++) send(rand_cmd(10));
    drain();
    stim_done = 1'b1;
  end

  // End of run.
  initial begin
    wait (stim_done);
    @(posedge clk);
    if (errors == 0 && path_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
